// ----- rtl/tpg_pkg.sv -----
`default_nettype none

package tpg_pkg;

  localparam int COUNT_BITS = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int WORD_BITS      = 16;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cnt_t CNT_MAX = '1;
  localparam cnt_t CNT_ONE = cnt_t'(1);

  // action modes
  localparam logic [1:0] MODE_PULSE_HIGH = 2'd0;
  localparam logic [1:0] MODE_PULSE_LOW  = 2'd1;
  localparam logic [1:0] MODE_TOGGLE     = 2'd2;
  localparam logic [1:0] MODE_REPEAT     = 2'd3;

  // register indexes
  localparam cfg_index_t REG_ACTION_MODE      = cfg_index_t'(0);
  localparam cfg_index_t REG_PULSE_TICKS      = cfg_index_t'(1);
  localparam cfg_index_t REG_REPEAT_TICKS     = cfg_index_t'(2);
  localparam cfg_index_t REG_SERVO_HIGH_WIDTH = cfg_index_t'(3);
  localparam cfg_index_t REG_SERVO_LOW_WIDTH  = cfg_index_t'(4);

  // item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic [1:0] action_mode;
    word_t      pulse_ticks;
    word_t      repeat_ticks;
    word_t      servo_high_width;
    word_t      servo_low_width;
  } cfg_t;

  typedef struct packed {
    logic  action_level;
    word_t servo_width;
  } result_t;

  // saturate a register value into a countdown
  function automatic cnt_t sat_load(input word_t v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return cnt_t'(wide);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tpg_cfg_regs.sv -----
`default_nettype none

module tpg_cfg_regs (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire tpg_pkg::cfg_index_t   cfg_index,
  input  wire tpg_pkg::word_t        cfg_data,
  output tpg_pkg::cfg_t              cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.action_mode      <= tpg_pkg::MODE_PULSE_HIGH;
      cfg.pulse_ticks      <= tpg_pkg::word_t'(20);
      cfg.repeat_ticks     <= tpg_pkg::word_t'(40);
      cfg.servo_high_width <= tpg_pkg::word_t'(4000);
      cfg.servo_low_width  <= tpg_pkg::word_t'(2000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpg_pkg::REG_ACTION_MODE:      cfg.action_mode      <= cfg_data[1:0];
        tpg_pkg::REG_PULSE_TICKS:      cfg.pulse_ticks      <= cfg_data;
        tpg_pkg::REG_REPEAT_TICKS:     cfg.repeat_ticks     <= cfg_data;
        tpg_pkg::REG_SERVO_HIGH_WIDTH: cfg.servo_high_width <= cfg_data;
        tpg_pkg::REG_SERVO_LOW_WIDTH:  cfg.servo_low_width  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tpg_core.sv -----
`default_nettype none

module tpg_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic            kind,
  input  wire logic            trigger_request,
  input  wire tpg_pkg::cfg_t   cfg,
  output tpg_pkg::result_t     result
);

  tpg_pkg::cnt_t start_countdown;
  tpg_pkg::cnt_t stop_countdown;
  logic          level_now;
  logic          request_armed;

  tpg_pkg::cnt_t start_countdown_next;
  tpg_pkg::cnt_t stop_countdown_next;
  logic          level_now_next;
  logic          request_armed_next;

  always_comb begin
    start_countdown_next = start_countdown;
    stop_countdown_next  = stop_countdown;
    level_now_next       = level_now;
    request_armed_next   = request_armed;

    if (kind == tpg_pkg::KIND_REQUEST) begin
      request_armed_next = trigger_request;
      if (trigger_request) begin
        if (start_countdown == '0) begin
          start_countdown_next = tpg_pkg::CNT_ONE;
        end
      end else begin
        start_countdown_next = '0;
      end
    end else begin
      // stop side first, start side may override
      if (stop_countdown == tpg_pkg::CNT_ONE) begin
        level_now_next      = (cfg.action_mode != tpg_pkg::MODE_PULSE_HIGH);
        stop_countdown_next = '0;
      end else if (stop_countdown != '0) begin
        stop_countdown_next = stop_countdown - tpg_pkg::CNT_ONE;
      end

      if (start_countdown == tpg_pkg::CNT_ONE && request_armed) begin
        case (cfg.action_mode) inside
          tpg_pkg::MODE_PULSE_HIGH, tpg_pkg::MODE_PULSE_LOW: begin
            level_now_next       = (cfg.action_mode == tpg_pkg::MODE_PULSE_HIGH);
            stop_countdown_next  = tpg_pkg::sat_load(cfg.pulse_ticks);
            start_countdown_next = '0;
          end
          tpg_pkg::MODE_TOGGLE: begin
            level_now_next       = ~level_now_next;
            stop_countdown_next  = '0;
            start_countdown_next = '0;
          end
          default: begin
            level_now_next       = 1'b0;
            stop_countdown_next  = tpg_pkg::sat_load(cfg.pulse_ticks);
            start_countdown_next = tpg_pkg::sat_load(cfg.repeat_ticks);
          end
        endcase
      end else if (start_countdown != '0) begin
        start_countdown_next = start_countdown - tpg_pkg::CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_countdown <= '0;
      stop_countdown  <= '0;
      level_now       <= 1'b0;
      request_armed   <= 1'b0;
    end else if (step) begin
      start_countdown <= start_countdown_next;
      stop_countdown  <= stop_countdown_next;
      level_now       <= level_now_next;
      request_armed   <= request_armed_next;
    end
  end

  assign result.action_level = level_now_next;
  assign result.servo_width  = level_now_next ? cfg.servo_high_width : cfg.servo_low_width;

endmodule

`default_nettype wire

// ----- rtl/trigger_pulse_generator.sv -----
`default_nettype none

// channel   direction  handshake                  payload
// s_axis    in         s_tvalid / s_tready        s_tdata, s_tuser
// m_axis    out        m_tvalid / m_tready        m_tdata
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// an accepted item is held in the input register, then its result is
// computed and loaded into the output register
// one item per clock sustained; the output register stalls the input stage
// only when a result is held and m_tready is low
// rst clears the countdowns, the level, the arm flag and the valid flags, and loads the cfg defaults

module trigger_pulse_generator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [0] trigger_request
  input  wire logic                s_tuser,   // [0] kind
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata,   // [0] action_level, [16:1] servo_width
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire tpg_pkg::cfg_index_t cfg_index,
  input  wire tpg_pkg::word_t      cfg_data
);

  tpg_pkg::cfg_t    cfg;
  tpg_pkg::result_t result;

  logic in_valid;
  logic in_kind;
  logic in_trigger;
  logic step;

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind    <= s_tuser;
      in_trigger <= s_tdata[0];
    end
  end

  tpg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpg_core u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .kind            (in_kind),
    .trigger_request (in_trigger),
    .cfg             (cfg),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {7'b0, result.servo_width, result.action_level};
    end
  end

endmodule

`default_nettype wire
